@@ hw/rtl/kit_pkg.sv @@
// Shared types, constants and keyword table for the keyword indent tracker.
// No dependencies; kit_cfg, kit_scan and the top level import this package.
`default_nettype none

package kit_pkg;

  localparam int WORD_CHARS_DEF  = 7;
  localparam int INDENT_BITS_DEF = 8;
  localparam int KW_NUM          = 14;
  localparam int KW_CHARS        = 7;
  localparam int CFG_AW          = 3;

  localparam logic [7:0] MAX_INDENT_RST = 8'd16;

  // register index taken from the word address
  localparam logic CFG_IDX_MAX_INDENT = 1'b0;

  typedef struct packed {
    logic       eol;
    logic [7:0] line_indent;
    logic [7:0] next_indent;
  } kit_line_t;

  // Keyword text, right-justified: first character in the highest used byte.
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
    56'("proc"), 56'("iter"), 56'("if"), 56'("while"), 56'("for"),
    56'("begin"), 56'("tagcase"), 56'("except"),
    56'("when"), 56'("tag"), 56'("others"), 56'("else"), 56'("elseif"),
    56'("end")
  };

  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd4, 3'd4, 3'd2, 3'd5, 3'd3, 3'd5, 3'd7, 3'd6,
    3'd4, 3'd3, 3'd6, 3'd4, 3'd6,
    3'd3
  };

  // magnitude of the negative line offset
  localparam logic [1:0] KW_OFF [KW_NUM] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd2
  };

  localparam logic signed [2:0] KW_CHG [KW_NUM] = '{
    3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2,
    3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0,
    -3'sd2
  };

  // Character i of keyword k, zero past its end.
  function automatic logic [7:0] kw_char(input int k, input int i);
    int len;
    len = int'(KW_LEN[k]);
    if (i < len) return KW_TEXT[k][8*(len-1-i) +: 8];
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/kit_ifs.sv @@
// Valid/ready channel interfaces for the keyword indent tracker.
// Depends on nothing; used by the top level.
`default_nettype none

interface kit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface kit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_indent;
  logic [7:0] next_indent;

  modport source (output valid, output line_indent, output next_indent, input ready);
  modport sink   (input valid, input line_indent, input next_indent, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/kit_cfg.sv @@
// APB-style register port holding max_indent.
// Depends on kit_pkg.
`default_nettype none

module kit_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kit_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [7:0]                max_indent
);
  import kit_pkg::*;

  logic [7:0] max_indent_r;
  logic       wr_en;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite;
  assign max_indent = max_indent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_indent_r <= MAX_INDENT_RST;
    end else if (wr_en && (paddr[CFG_AW-1] == CFG_IDX_MAX_INDENT)) begin
      max_indent_r <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (paddr[CFG_AW-1])
      CFG_IDX_MAX_INDENT: prdata = {24'h000000, max_indent_r};
      default:            prdata = 32'h0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/kit_scan.sv @@
// Per-line scanner: scan mode, escapes, identifier capture, keyword match,
// line offset/change and the running indent. Depends on kit_pkg.
`default_nettype none

module kit_scan #(
  parameter int WORD_CHARS  = kit_pkg::WORD_CHARS_DEF,
  parameter int INDENT_BITS = kit_pkg::INDENT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        text_byte,
  input  wire logic [7:0]        max_indent,
  output kit_pkg::kit_line_t     line
);
  import kit_pkg::*;

  localparam int IB   = INDENT_BITS;
  localparam int LW   = $clog2(WORD_CHARS + 2);
  localparam int PADN = (WORD_CHARS > KW_CHARS) ? WORD_CHARS : KW_CHARS;
  localparam int OW   = (IB > 8) ? IB : 8;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_STR    = 4'b0010,
    MODE_CHR    = 4'b0100,
    MODE_CMT    = 4'b1000
  } mode_t;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_OCT2 = 2'd2;
  localparam logic [1:0] ESC_PEND = 2'd3;

  mode_t                mode_r;
  logic [1:0]           esc_r;
  logic [7:0]           chars_r [WORD_CHARS];
  logic [LW-1:0]        len_r;
  logic                 seen_r;
  logic [1:0]           off_r;
  logic signed [IB-1:0] chg_r;
  logic [IB-1:0]        run_r;

  logic [7:0]           pad [PADN];
  logic                 eol, wbyte, has_word, do_end, hit, is_close;
  logic [1:0]           kw_off, off1;
  logic signed [2:0]    kw_chg, brk;
  logic signed [IB-1:0] chg1, chg2;
  logic [IB-1:0]        run_nxt;
  logic signed [IB+1:0] nsum;
  logic signed [IB:0]   hsum;
  logic [OW-1:0]        here_x, run_x;

  function automatic logic signed [IB-1:0] sat_add(input logic signed [IB-1:0] a,
                                                   input logic signed [2:0] d);
    logic signed [IB:0] s;
    s = {a[IB-1], a} + {{(IB-2){d[2]}}, d};
    if (s[IB] != s[IB-1]) return s[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
    return s[IB-1:0];
  endfunction

  // word buffer padded with zeros up to the longest keyword
  for (genvar g = 0; g < PADN; g++) begin : g_pad
    if (g < WORD_CHARS) begin : g_buf
      assign pad[g] = chars_r[g];
    end else begin : g_zero
      assign pad[g] = 8'h00;
    end
  end

  always_comb begin
    logic same;
    hit    = 1'b0;
    kw_off = 2'd0;
    kw_chg = 3'sd0;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      same = (len_r == LW'(KW_LEN[k]));
      for (int i = 0; i < KW_CHARS; i++) begin
        if (pad[i] != kw_char(k, i)) same = 1'b0;
      end
      if (same) begin
        hit    = 1'b1;
        kw_off = KW_OFF[k];
        kw_chg = KW_CHG[k];
      end
    end
  end

  assign eol   = (text_byte == 8'd10) || (text_byte == 8'd0);
  assign wbyte = ((text_byte >= "a") && (text_byte <= "z")) ||
                 ((text_byte >= "A") && (text_byte <= "Z")) || (text_byte == "_");
  assign has_word = (len_r != '0);
  assign do_end   = (mode_r == MODE_NORMAL) && (eol || !wbyte);

  always_comb begin
    off1 = off_r;
    chg1 = chg_r;
    if (do_end && has_word && hit) begin
      if (!seen_r) off1 = kw_off;
      chg1 = sat_add(chg_r, kw_chg);
    end
    if ((text_byte == "(") || (text_byte == "[") || (text_byte == "{")) brk = 3'sd2;
    else if ((text_byte == ")") || (text_byte == "]") || (text_byte == "}")) brk = -3'sd2;
    else brk = 3'sd0;
    chg2 = sat_add(chg1, brk);
  end

  // line end arithmetic
  always_comb begin
    nsum = {2'b00, run_r} + {{2{chg1[IB-1]}}, chg1};
    if (nsum[IB+1])   run_nxt = '0;
    else if (nsum[IB]) run_nxt = '1;
    else              run_nxt = nsum[IB-1:0];

    hsum = {1'b0, run_r} - {{(IB-1){1'b0}}, off1};
    here_x = hsum[IB] ? '0 : OW'(hsum[IB-1:0]);
    run_x  = OW'(run_nxt);

    line.eol         = eol;
    line.line_indent = (here_x > OW'(max_indent)) ? max_indent : here_x[7:0];
    line.next_indent = (run_x > OW'(8'hFF)) ? 8'hFF : run_x[7:0];
  end

  assign is_close = (mode_r == MODE_STR) ? (text_byte == "\"") : (text_byte == "'");

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      esc_r  <= ESC_NONE;
      len_r  <= '0;
      seen_r <= 1'b0;
      off_r  <= 2'd0;
      chg_r  <= '0;
      run_r  <= '0;
      for (int i = 0; i < WORD_CHARS; i++) chars_r[i] <= 8'h00;
    end else if (step) begin
      if (eol) begin
        run_r  <= run_nxt;
        mode_r <= MODE_NORMAL;
        esc_r  <= ESC_NONE;
        len_r  <= '0;
        seen_r <= 1'b0;
        off_r  <= 2'd0;
        chg_r  <= '0;
        for (int i = 0; i < WORD_CHARS; i++) chars_r[i] <= 8'h00;
      end else begin
        unique case (mode_r)
          MODE_NORMAL: begin
            if (wbyte) begin
              for (int i = 0; i < WORD_CHARS; i++) begin
                if (len_r == LW'(i)) chars_r[i] <= text_byte;
              end
              if (len_r <= LW'(WORD_CHARS)) len_r <= len_r + LW'(1);
            end else begin
              if (has_word) begin
                seen_r <= 1'b1;
                len_r  <= '0;
                for (int i = 0; i < WORD_CHARS; i++) chars_r[i] <= 8'h00;
              end
              off_r <= off1;
              chg_r <= chg2;
              if (text_byte == "\"")     mode_r <= MODE_STR;
              else if (text_byte == "'") mode_r <= MODE_CHR;
              else if (text_byte == "%") mode_r <= MODE_CMT;
            end
          end
          MODE_STR, MODE_CHR: begin
            if (esc_r == ESC_PEND) begin
              esc_r <= ((text_byte >= "0") && (text_byte <= "7")) ? ESC_OCT2 : ESC_NONE;
            end else if (esc_r != ESC_NONE) begin
              esc_r <= esc_r - 2'd1;
            end else if (is_close) begin
              mode_r <= MODE_NORMAL;
            end else if (text_byte == "\\") begin
              esc_r <= ESC_PEND;
            end
          end
          MODE_CMT: begin
          end
          default: begin
            mode_r <= MODE_NORMAL;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/keyword_indent_tracker.sv @@
// Keyword indent tracker, top level: input byte register, scanner, result register.
// Order: a taken byte is held in the input byte register and scanned from there; a line
//   result is captured in the result register when its line-end byte is scanned.
// Throughput: one byte per cycle; a result held by out_chan.ready stalls the input.
// Reset: synchronous active-low rst_n clears all scan state; max_indent returns to 16.
`default_nettype none

module keyword_indent_tracker #(
  parameter int WORD_CHARS  = kit_pkg::WORD_CHARS_DEF,
  parameter int INDENT_BITS = kit_pkg::INDENT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  kit_in_if.sink                          in_chan,
  kit_out_if.source                       out_chan,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [kit_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import kit_pkg::*;

  logic       byte_vld_r;
  logic [7:0] byte_r;
  logic       out_vld_r;
  logic [7:0] line_indent_r;
  logic [7:0] next_indent_r;
  logic       adv;
  logic [7:0] max_indent;
  kit_line_t  line;

  kit_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_indent (max_indent)
  );

  kit_scan #(
    .WORD_CHARS  (WORD_CHARS),
    .INDENT_BITS (INDENT_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .text_byte  (byte_r),
    .max_indent (max_indent),
    .line       (line)
  );

  // scanner advances when a byte is held and the result slot is free or draining
  assign adv           = byte_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !byte_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      byte_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) byte_r <= in_chan.text_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && line.eol) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && line.eol) begin
      line_indent_r <= line.line_indent;
      next_indent_r <= line.next_indent;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.line_indent = line_indent_r;
  assign out_chan.next_indent = next_indent_r;

endmodule

`default_nettype wire
